@@ design/slps_pkg.sv @@
// Shared types, codes and blink pattern tables for the status LED pattern sequencer.
package slps_pkg;

	localparam int CFG_IDX_W = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BOOT_STEP_MS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOOT_ROUNDS  = 8'd1;

	// Reset values of the configuration registers.
	localparam logic [15:0] BOOT_STEP_MS_RST = 16'd200;
	localparam logic [1:0]  BOOT_ROUNDS_RST  = 2'd2;

	// LED modes.
	localparam logic [2:0] MODE_BOOT   = 3'd0;
	localparam logic [2:0] MODE_CRIT   = 3'd1;
	localparam logic [2:0] MODE_LIGHT  = 3'd2;
	localparam logic [2:0] MODE_TEMP   = 3'd3;
	localparam logic [2:0] MODE_MQTT   = 3'd4;
	localparam logic [2:0] MODE_WIFI   = 3'd5;
	localparam logic [2:0] MODE_NORMAL = 3'd6;

	// Colour codes.
	localparam logic [1:0] COL_OFF   = 2'd0;
	localparam logic [1:0] COL_RED   = 2'd1;
	localparam logic [1:0] COL_GREEN = 2'd2;
	localparam logic [1:0] COL_BLUE  = 2'd3;

	localparam logic [7:0] LED_FULL = 8'd255;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        wifi_ok;
		logic        mqtt_ok;
		logic        light_alarm;
		logic        fan_on;
	} slps_in_t;

	typedef struct packed {
		logic       led_write;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [2:0] led_mode;
	} slps_out_t;

	typedef struct packed {
		logic [15:0] boot_step_ms;
		logic [1:0]  boot_rounds;
	} slps_cfg_t;

	// Number of steps in the pattern of a mode.
	function automatic logic [3:0] pat_len(input logic [2:0] mode);
		logic [3:0] len;
		case (mode)
			MODE_CRIT:   len = 4'd12;
			MODE_LIGHT:  len = 4'd6;
			MODE_TEMP:   len = 4'd4;
			MODE_MQTT:   len = 4'd5;
			MODE_WIFI:   len = 4'd3;
			MODE_NORMAL: len = 4'd6;
			default:     len = 4'd1;
		endcase
		return len;
	endfunction

	// Colour shown at one step of a pattern.
	function automatic logic [1:0] pat_col(input logic [2:0] mode, input logic [3:0] step);
		logic [1:0] col;
		col = COL_OFF;
		case (mode)
			MODE_CRIT: begin
				case (step)
					4'd0, 4'd2: col = COL_RED;
					4'd4, 4'd6: col = COL_GREEN;
					4'd8, 4'd10: col = COL_BLUE;
					default: col = COL_OFF;
				endcase
			end
			MODE_LIGHT: begin
				case (step)
					4'd0: col = COL_RED;
					4'd2: col = COL_GREEN;
					4'd4: col = COL_BLUE;
					default: col = COL_OFF;
				endcase
			end
			MODE_TEMP: begin
				case (step)
					4'd0: col = COL_RED;
					4'd1: col = COL_GREEN;
					4'd2: col = COL_BLUE;
					default: col = COL_OFF;
				endcase
			end
			MODE_MQTT: begin
				case (step)
					4'd0: col = COL_RED;
					4'd1: col = COL_GREEN;
					4'd3: col = COL_BLUE;
					default: col = COL_OFF;
				endcase
			end
			MODE_WIFI: begin
				case (step)
					4'd0: col = COL_RED;
					4'd1: col = COL_GREEN;
					default: col = COL_OFF;
				endcase
			end
			MODE_NORMAL: begin
				case (step)
					4'd1: col = COL_RED;
					4'd2: col = COL_GREEN;
					4'd3: col = COL_BLUE;
					default: col = COL_OFF;
				endcase
			end
			default: col = COL_OFF;
		endcase
		return col;
	endfunction

	// Duration in ms of one step of a pattern.
	function automatic logic [10:0] pat_dur(input logic [2:0] mode, input logic [3:0] step);
		logic [10:0] dur;
		dur = 11'd0;
		case (mode)
			MODE_CRIT: begin
				if (step == 4'd11) begin
					dur = 11'd350;
				end else if (step[0]) begin
					dur = 11'd50;
				end else begin
					dur = 11'd100;
				end
			end
			MODE_LIGHT: dur = step[0] ? 11'd200 : 11'd300;
			MODE_TEMP: dur = (step == 4'd3) ? 11'd700 : 11'd500;
			MODE_MQTT: dur = 11'd500;
			MODE_WIFI: dur = (step == 4'd2) ? 11'd500 : 11'd200;
			MODE_NORMAL: begin
				case (step)
					4'd0: dur = 11'd0;
					4'd5: dur = 11'd200;
					default: dur = 11'd1000;
				endcase
			end
			default: dur = 11'd0;
		endcase
		return dur;
	endfunction

	// Drive one channel at full intensity for a colour code; COL_OFF drives none.
	function automatic logic [23:0] col_rgb(input logic [1:0] col);
		logic [23:0] rgb;
		rgb = 24'd0;
		case (col)
			COL_RED:   rgb = {LED_FULL, 8'd0, 8'd0};
			COL_GREEN: rgb = {8'd0, LED_FULL, 8'd0};
			COL_BLUE:  rgb = {8'd0, 8'd0, LED_FULL};
			default:   rgb = 24'd0;
		endcase
		return rgb;
	endfunction

endpackage

@@ design/status_led_pattern_sequencer.sv @@
// Top level of the status LED pattern sequencer: input register, configuration and result register.
// Each input beat is one update carrying a millisecond timestamp and four status flags, and it
// produces exactly one result beat with the write strobe, the RGB colour and the mode after the
// update. A new beat can be accepted in every cycle while the output is not stalled; the result
// beat is registered in the input register and then in the result register, where it is presented.
// The rate is set by the update of the sequencer state (mode, pattern step, step start time and
// boot progress), which each beat reads and rewrites before the next one.
// Configuration writes are always accepted and must be made while no update is in flight.
module status_led_pattern_sequencer import slps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  slps_in_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output slps_out_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	slps_cfg_t cfg_q;
	slps_in_t  item_s1;
	logic      valid_s1;
	logic      advance;
	slps_out_t result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boot_step_ms <= BOOT_STEP_MS_RST;
			cfg_q.boot_rounds  <= BOOT_ROUNDS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BOOT_STEP_MS: cfg_q.boot_step_ms <= cfg_data;
				CFG_BOOT_ROUNDS:  cfg_q.boot_rounds  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// The update fires when a beat is held in the input register and the result register is free or is being emptied.
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	slps_update u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data <= result;
		end
	end

endmodule

@@ design/slps_update.sv @@
// Sequencer state and the update logic for one timestamped status beat.
module slps_update import slps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  slps_in_t  item,
	input  slps_cfg_t cfg,
	output slps_out_t result
);

	logic [2:0]  mode_q;
	logic [3:0]  step_q;
	logic [31:0] start_q;
	logic [1:0]  phase_q;
	logic [1:0]  count_q;

	logic [2:0]  mode_d;
	logic [3:0]  step_d;
	logic [31:0] start_d;
	logic [1:0]  phase_d;
	logic [1:0]  count_d;

	logic [31:0] elapsed;
	logic [2:0]  new_mode;
	logic [3:0]  len;
	logic [3:0]  step_cur;
	logic [3:0]  step_inc;
	logic [1:0]  col;
	logic [23:0] rgb;

	assign elapsed = item.now_ms - start_q;

	// Fixed priority after boot.
	always_comb begin
		if (item.light_alarm && item.fan_on) begin
			new_mode = MODE_CRIT;
		end else if (item.light_alarm) begin
			new_mode = MODE_LIGHT;
		end else if (item.fan_on) begin
			new_mode = MODE_TEMP;
		end else if (!item.mqtt_ok) begin
			new_mode = MODE_MQTT;
		end else if (!item.wifi_ok) begin
			new_mode = MODE_WIFI;
		end else begin
			new_mode = MODE_NORMAL;
		end
	end

	assign len = pat_len(new_mode);

	always_comb begin
		mode_d  = mode_q;
		step_d  = step_q;
		start_d = start_q;
		phase_d = phase_q;
		count_d = count_q;
		result  = '0;
		step_cur = 4'd0;
		step_inc = 4'd0;
		col = COL_OFF;
		rgb = 24'd0;

		if (mode_q == MODE_BOOT) begin
			if (elapsed > {16'd0, cfg.boot_step_ms}) begin
				start_d = item.now_ms;
				phase_d = (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
				// Each return to the first colour completes a round.
				if (phase_d == 2'd0) begin
					count_d = count_q + 2'd1;
				end
				result.led_write = 1'b1;
				if (count_d >= cfg.boot_rounds) begin
					mode_d = MODE_NORMAL;
				end else begin
					rgb = col_rgb(phase_d + 2'd1);
					{result.red, result.green, result.blue} = rgb;
				end
			end
		end else begin
			if (new_mode != mode_q) begin
				// A new mode restarts its pattern from now, so no step can be due.
				mode_d   = new_mode;
				start_d  = item.now_ms;
				step_cur = 4'd0;
			end else begin
				step_cur = (step_q >= len) ? 4'd0 : step_q;
				if (elapsed > {21'd0, pat_dur(new_mode, step_cur)}) begin
					start_d  = item.now_ms;
					step_inc = step_cur + 4'd1;
					if (step_inc >= len) begin
						step_cur = (new_mode == MODE_NORMAL) ? 4'd1 : 4'd0;
					end else begin
						step_cur = step_inc;
					end
				end
			end
			step_d = step_cur;
			col = pat_col(new_mode, step_cur);
			rgb = col_rgb(col);
			result.led_write = 1'b1;
			{result.red, result.green, result.blue} = rgb;
		end
		result.led_mode = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BOOT;
			step_q  <= 4'd0;
			start_q <= 32'd0;
			phase_q <= 2'd0;
			count_q <= 2'd0;
		end else if (en) begin
			mode_q  <= mode_d;
			step_q  <= step_d;
			start_q <= start_d;
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

endmodule
